// ===== rtl/tsrt_pkg.sv =====
// Shared constants, codes and types for the transfer slot ring tracker.
package tsrt_pkg;

    // Ring geometry and field widths.
    localparam int unsigned SLOTS      = 1024;
    localparam int unsigned SLOT_BYTES = 16384;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned LEN_W      = 15;
    localparam int unsigned CNT_W      = 25;
    localparam int unsigned KIND_W     = 2;

    // One memory entry holds the pending mark above the stored length.
    localparam int unsigned ENTRY_W    = LEN_W + 1;

    // Sized forms of the geometry constants.
    localparam logic [IDX_W:0]     SLOTS_L      = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W-1:0]   LAST_SLOT_L  = IDX_W'(SLOTS - 1);
    localparam logic [LEN_W-1:0]   SLOT_BYTES_L = LEN_W'(SLOT_BYTES);

    // Input item kinds carried on tuser.
    localparam logic [KIND_W-1:0] KIND_RESERVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;

    // Read walk sequencer states.
    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_REQ,
        WALK_CHK,
        WALK_DONE
    } walk_state_t;

    // Outcome of a read walk, handed from the sequencer to the top level.
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] next_pop;
        logic [CNT_W-1:0] count;
    } walk_res_t;

endpackage

// ===== rtl/transfer_slot_ring_tracker_unit.sv =====
// Top level of the transfer slot ring tracker: handshakes, pointers and result register.
//
//  channel | dir | fields
//  s_*     | in  | tuser: kind[1:0]; tdata: slot[9:0], ok[10], length[25:11]
//  m_*     | out | tdata: slot_index[9:0], byte_count[34:10]
//
// Reserve and completion items may follow back to back.
// A read of a non-empty ring starts a walk over full slots that ends at a pending or short
// slot, the push pointer or the ring end; its result is registered once the walk is done
// and the result register is free. An empty ring answers at once. The walk reads each slot
// entry through the slot memory and its registered read, and input waits until it ends.
// The result register frees the input side once a result is taken or empty.
// Reset clears the pointers and the control state; slot memory is not cleared.
// A stalled m_tready holds the result and blocks further input items.
module transfer_slot_ring_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slot[9:0], ok[10], length[25:11], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // slot_index[9:0], byte_count[34:10], zero fill
);

    logic [tsrt_pkg::IDX_W-1:0]   push_reg, push_next;
    logic [tsrt_pkg::IDX_W-1:0]   pop_reg, pop_next;
    logic                         out_valid_reg, out_valid_next;
    logic [tsrt_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [tsrt_pkg::CNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic [tsrt_pkg::KIND_W-1:0]  in_kind;
    logic [tsrt_pkg::IDX_W-1:0]   in_slot;
    logic                         in_ok;
    logic [tsrt_pkg::LEN_W-1:0]   in_length;

    logic                         out_free;
    logic                         accept;
    logic                         walk_start;
    logic                         walk_ack;
    logic                         walk_busy;
    tsrt_pkg::walk_res_t          walk_res;

    logic                         wr_en;
    logic [tsrt_pkg::IDX_W-1:0]   wr_addr;
    logic [tsrt_pkg::ENTRY_W-1:0] wr_data;
    logic                         rd_en;
    logic [tsrt_pkg::IDX_W-1:0]   rd_addr;
    logic [tsrt_pkg::ENTRY_W-1:0] rd_data;

    // Unpack the input transfer.
    assign in_kind   = s_tuser;
    assign in_slot   = s_tdata[9:0];
    assign in_ok     = s_tdata[10];
    assign in_length = s_tdata[25:11];

    // Handshake: take an item when no walk runs and the result slot is free.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !walk_busy && out_free;
    assign accept   = s_tvalid && s_tready;

    assign walk_start = accept && (in_kind == tsrt_pkg::KIND_READ) && (push_reg != pop_reg);
    assign walk_ack   = walk_res.done && out_free;

    // Slot memory writes for reserve and completion.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = push_reg;
        wr_data = {1'b1, {tsrt_pkg::LEN_W{1'b0}}};
        if (accept)
        begin
            case (in_kind)
                tsrt_pkg::KIND_RESERVE:
                begin
                    wr_en = 1'b1;
                end
                tsrt_pkg::KIND_COMPLETE:
                begin
                    wr_en   = ({1'b0, in_slot} < tsrt_pkg::SLOTS_L);
                    wr_addr = in_slot;
                    wr_data = {1'b0, in_ok ? in_length : {tsrt_pkg::LEN_W{1'b0}}};
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Pointer and result register updates.
    always_comb
    begin
        push_next      = push_reg;
        pop_next       = pop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        if (walk_ack)
        begin
            pop_next       = walk_res.next_pop;
            out_valid_next = 1'b1;
            out_idx_next   = pop_reg;
            out_cnt_next   = walk_res.count;
        end
        else if (accept)
        begin
            case (in_kind)
                tsrt_pkg::KIND_RESERVE:
                begin
                    push_next      = (push_reg == tsrt_pkg::LAST_SLOT_L) ? '0 :
                                     push_reg + tsrt_pkg::IDX_W'(1);
                    out_valid_next = 1'b1;
                    out_idx_next   = push_reg;
                    out_cnt_next   = '0;
                end
                tsrt_pkg::KIND_COMPLETE:
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = in_slot;
                    out_cnt_next   = '0;
                end
                tsrt_pkg::KIND_READ:
                begin
                    // An empty ring answers at once; otherwise the walk answers later.
                    if (push_reg == pop_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = pop_reg;
                        out_cnt_next   = '0;
                    end
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg      <= '0;
            pop_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            push_reg      <= push_next;
            pop_reg       <= pop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg <= out_idx_next;
        out_cnt_reg <= out_cnt_next;
    end

    // Result transfer.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_cnt_reg, out_idx_reg};

    tsrt_slot_ram #(
        .DEPTH (tsrt_pkg::SLOTS),
        .WIDTH (tsrt_pkg::ENTRY_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsrt_walk_seq u_walk_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .start_idx (pop_reg),
        .push_ptr  (push_reg),
        .rd_data   (rd_data),
        .done_ack  (walk_ack),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .busy      (walk_busy),
        .res       (walk_res)
    );

endmodule

// ===== rtl/tsrt_slot_ram.sv =====
// Slot memory with one write port and one registered read port.
module tsrt_slot_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tsrt_walk_seq.sv =====
// Read walk sequencer: steps through slots with one shared byte adder.
module tsrt_walk_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tsrt_pkg::IDX_W-1:0]        start_idx,
    input  logic [tsrt_pkg::IDX_W-1:0]        push_ptr,
    input  logic [tsrt_pkg::ENTRY_W-1:0]      rd_data,
    input  logic                              done_ack,
    output logic                              rd_en,
    output logic [tsrt_pkg::IDX_W-1:0]        rd_addr,
    output logic                              busy,
    output tsrt_pkg::walk_res_t               res
);

    tsrt_pkg::walk_state_t           state_reg, state_next;
    logic [tsrt_pkg::IDX_W:0]        idx_reg, idx_next;
    logic [tsrt_pkg::CNT_W-1:0]      acc_reg, acc_next;

    logic                            at_end;
    logic                            entry_pending;
    logic [tsrt_pkg::LEN_W-1:0]      entry_len;
    logic                            entry_full;
    logic [tsrt_pkg::LEN_W-1:0]      add_b;
    logic [tsrt_pkg::CNT_W-1:0]      sum;
    logic [tsrt_pkg::IDX_W:0]        idx_inc;
    logic                            walk_done;

    // Decode the slot entry and the walk limits.
    assign at_end        = (idx_reg == tsrt_pkg::SLOTS_L) ||
                           (idx_reg[tsrt_pkg::IDX_W-1:0] == push_ptr);
    assign entry_pending = rd_data[tsrt_pkg::ENTRY_W-1];
    assign entry_len     = rd_data[tsrt_pkg::LEN_W-1:0];
    assign entry_full    = (entry_len >= tsrt_pkg::SLOT_BYTES_L);

    // Shared adder: a full slot adds the slot size, a short one its length.
    assign add_b   = entry_full ? tsrt_pkg::SLOT_BYTES_L : entry_len;
    assign sum     = acc_reg + tsrt_pkg::CNT_W'(add_b);
    assign idx_inc = idx_reg + (tsrt_pkg::IDX_W + 1)'(1);

    // Next state and datapath.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            tsrt_pkg::WALK_IDLE:
            begin
                if (start)
                begin
                    idx_next   = {1'b0, start_idx};
                    acc_next   = '0;
                    state_next = tsrt_pkg::WALK_REQ;
                end
            end
            tsrt_pkg::WALK_REQ:
            begin
                state_next = at_end ? tsrt_pkg::WALK_DONE : tsrt_pkg::WALK_CHK;
            end
            tsrt_pkg::WALK_CHK:
            begin
                if (entry_pending)
                begin
                    state_next = tsrt_pkg::WALK_DONE;
                end
                else
                begin
                    acc_next   = sum;
                    idx_next   = idx_inc;
                    state_next = entry_full ? tsrt_pkg::WALK_REQ : tsrt_pkg::WALK_DONE;
                end
            end
            tsrt_pkg::WALK_DONE:
            begin
                if (done_ack)
                begin
                    state_next = tsrt_pkg::WALK_IDLE;
                end
            end
            default:
            begin
                state_next = tsrt_pkg::WALK_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        rd_en     = 1'b0;
        busy      = 1'b1;
        walk_done = 1'b0;
        unique case (state_reg)
            tsrt_pkg::WALK_IDLE: busy      = 1'b0;
            tsrt_pkg::WALK_REQ:  rd_en     = !at_end;
            tsrt_pkg::WALK_CHK:  rd_en     = 1'b0;
            tsrt_pkg::WALK_DONE: walk_done = 1'b1;
            default:             busy      = 1'b0;
        endcase
    end

    assign rd_addr      = idx_reg[tsrt_pkg::IDX_W-1:0];
    assign res.done     = walk_done;
    assign res.count    = acc_reg;
    assign res.next_pop = (idx_reg == tsrt_pkg::SLOTS_L) ? '0 : idx_reg[tsrt_pkg::IDX_W-1:0];

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsrt_pkg::WALK_IDLE;
            idx_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
        end
    end

    // A memory read is always followed by the check of its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> state_reg == tsrt_pkg::WALK_CHK)
        else $error("read issued without a following check");

    // The check state only ever looks at data that was just read.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsrt_pkg::WALK_CHK |-> $past(rd_en))
        else $error("slot check without a preceding read");

    // A finished walk holds its result until the top level takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.done && !done_ack |=> res.done && $stable(res.count) && $stable(res.next_pop))
        else $error("walk result changed before it was taken");

    // The walk never runs past the ring end.
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= tsrt_pkg::SLOTS_L)
        else $error("walk index beyond ring end");

endmodule

// ===== tb/sv/tb_transfer_slot_ring_tracker_unit.sv =====
// Self-checking testbench for the transfer slot ring tracker unit.
module tb_transfer_slot_ring_tracker_unit;

    import tsrt_pkg::*;

    // The one kind code that the block does not define.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int GAP_PCT         = 14;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TRAFFIC_ITEMS   = 420;
    localparam int DIRECTED_ROWS   = 25;
    localparam int SETTLE_CYCLES   = 64;
    localparam int REPORT_LIMIT    = 10;

    // One result transfer, laid out as on m_tdata: slot_index in the low bits.
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [IDX_W-1:0] slot_index;
    } ring_result_t;

    // One input transfer, with a typed-in result where pinned is set.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  slot;
        logic              ok;
        logic [LEN_W-1:0]  length;
        logic              pinned;
        ring_result_t      want;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // Ring state as the block should hold it.
    logic [LEN_W-1:0] slot_len [SLOTS];
    bit               slot_held [SLOTS];
    logic [IDX_W-1:0] push_ptr = '0;
    logic [IDX_W-1:0] pop_ptr  = '0;

    ring_result_t     awaited_results [$];
    logic [IDX_W-1:0] inflight_slots [$];

    bit no_gaps      = 1'b0;
    bit hold_off_req = 1'b0;

    int items_sent      = 0;
    int results_checked = 0;
    int reads_with_data = 0;
    int largest_count   = 0;
    int overrun_passes  = 0;
    int fail_count      = 0;
    int report_count    = 0;

    transfer_slot_ring_tracker_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Applies one accepted transfer to the ring state and returns its result.
    function automatic ring_result_t track_ring(input logic [KIND_W-1:0] kind,
                                                input logic [IDX_W-1:0] slot,
                                                input logic ok,
                                                input logic [LEN_W-1:0] length);
        ring_result_t res;
        int           first;
        int           walk;
        int           tail;
        bit           took_short;
        res = '0;
        case (kind)
            KIND_RESERVE:
            begin
                res.slot_index = push_ptr;
                slot_held[push_ptr] = 1'b1;
                push_ptr = push_ptr + 1'b1;
                if (push_ptr == pop_ptr)
                begin
                    overrun_passes++;
                end
            end
            KIND_COMPLETE:
            begin
                slot_len[slot]  = ok ? length : '0;
                slot_held[slot] = 1'b0;
                res.slot_index  = slot;
            end
            KIND_READ:
            begin
                res.slot_index = pop_ptr;
                if (push_ptr != pop_ptr)
                begin
                    first      = int'(pop_ptr);
                    walk       = first;
                    tail       = 0;
                    took_short = 1'b0;
                    // Full slots are taken whole; a short slot ends the run.
                    while (walk < int'(SLOTS) && walk != int'(push_ptr))
                    begin
                        if (slot_held[walk])
                        begin
                            break;
                        end
                        if (slot_len[walk] < SLOT_BYTES_L)
                        begin
                            tail       = int'(slot_len[walk]);
                            took_short = 1'b1;
                            break;
                        end
                        walk++;
                    end
                    res.byte_count = CNT_W'((walk - first) * int'(SLOT_BYTES) + tail);
                    if (took_short)
                    begin
                        walk++;
                    end
                    pop_ptr = (walk < int'(SLOTS)) ? IDX_W'(walk) : '0;
                    if (res.byte_count != 0)
                    begin
                        reads_with_data++;
                    end
                    if (int'(res.byte_count) > largest_count)
                    begin
                        largest_count = int'(res.byte_count);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Offers one transfer from the falling edge and waits for its acceptance.
    task automatic send_item(input stim_row_t row);
        ring_result_t predicted;
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < GAP_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.kind;
        s_tdata  <= {6'b0, row.length, row.ok, row.slot};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = track_ring(row.kind, row.slot, row.ok, row.length);
        awaited_results.push_back(row.pinned ? row.want : predicted);
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly reserve, complete and read in order, with some noise mixed in.
    task automatic run_traffic(input int n_items, input bit hold_once);
        stim_row_t row;
        int        pick;
        int        at;
        int        grade;
        for (int n = 0; n < n_items; n++)
        begin
            no_gaps = (n >= 200 && n < 320);
            if (hold_once && n == 100)
            begin
                hold_off_req = 1'b1;
            end
            row        = '0;
            row.slot   = IDX_W'($urandom);
            row.ok     = 1'($urandom);
            row.length = LEN_W'($urandom);
            pick       = $urandom_range(99);
            if (pick < 3)
            begin
                row.kind = KIND_UNUSED;
            end
            else if (pick < 6)
            begin
                // A completion for any slot, whether reserved or not.
                row.kind = KIND_COMPLETE;
            end
            else if (inflight_slots.size() == 0 || (pick < 48 && inflight_slots.size() < 24))
            begin
                row.kind = KIND_RESERVE;
                inflight_slots.push_back(push_ptr);
            end
            else if (pick < 86)
            begin
                row.kind = KIND_COMPLETE;
                at       = $urandom_range(inflight_slots.size() - 1);
                row.slot = inflight_slots[at];
                inflight_slots.delete(at);
                grade    = $urandom_range(9);
                if (grade == 0)
                begin
                    row.ok = 1'b0;
                end
                else
                begin
                    row.ok = 1'b1;
                    if (grade <= 5)
                    begin
                        row.length = SLOT_BYTES_L;
                    end
                    else if (grade == 6)
                    begin
                        row.length = LEN_W'($urandom_range(32767, SLOT_BYTES));
                    end
                    else
                    begin
                        row.length = LEN_W'($urandom_range(SLOT_BYTES - 1, 0));
                    end
                end
            end
            else
            begin
                row.kind = KIND_READ;
            end
            send_item(row);
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        ring_result_t seen;
        ring_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = ring_result_t'(m_tdata[IDX_W+CNT_W-1:0]);
            if (awaited_results.size() == 0)
            begin
                fail_count++;
                if (report_count < REPORT_LIMIT)
                begin
                    $display("unexpected result: slot_index %0d byte_count %0d",
                             seen.slot_index, seen.byte_count);
                end
                report_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (seen.slot_index !== want.slot_index ||
                    seen.byte_count !== want.byte_count)
                begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT)
                    begin
                        $display("result %0d: expected idx %0d count %0d, got idx %0d count %0d",
                                 results_checked, want.slot_index, want.byte_count,
                                 seen.slot_index, seen.byte_count);
                    end
                    report_count++;
                end
            end
        end
    end

    // Stimulus: directed rows, traffic, a full lap of reserves, more traffic.
    initial
    begin
        stim_row_t        directed_rows [DIRECTED_ROWS];
        stim_row_t        row;
        logic [IDX_W-1:0] occupancy;
        int               lap_items;

        // kind, slot, ok, length, pinned, {byte_count, slot_index}
        directed_rows = '{
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b1, '{25'd0, 10'd0}},
            '{KIND_UNUSED,   10'd1023, 1'b1, 15'h7FFF,  1'b1, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd1023, 1'b1, 15'h7FFF,  1'b1, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_COMPLETE, 10'd1,    1'b1, 15'd16384, 1'b0, '{25'd0, 10'd0}},
            '{KIND_COMPLETE, 10'd0,    1'b1, 15'h7FFF,  1'b1, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_COMPLETE, 10'd2,    1'b0, 15'h5555,  1'b1, '{25'd0, 10'd2}},
            '{KIND_COMPLETE, 10'd3,    1'b1, 15'h2AAA,  1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_COMPLETE, 10'd1023, 1'b1, 15'd1,     1'b1, '{25'd0, 10'd1023}},
            '{KIND_COMPLETE, 10'd682,  1'b1, 15'd16383, 1'b0, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_COMPLETE, 10'd4,    1'b1, 15'd16383, 1'b0, '{25'd0, 10'd0}},
            '{KIND_COMPLETE, 10'd5,    1'b1, 15'd16384, 1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_RESERVE,  10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}},
            '{KIND_READ,     10'd0,    1'b0, 15'd0,     1'b0, '{25'd0, 10'd0}}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            send_item(directed_rows[r]);
        end

        run_traffic(TRAFFIC_ITEMS, 1'b1);

        // Pause the sender until the ring is quiet, then reserve a full lap
        // so that the push pointer runs past the ring end and onto pop.
        drain_results();
        occupancy = push_ptr - pop_ptr;
        lap_items = int'(SLOTS) - int'(occupancy) + 3;
        inflight_slots.delete();
        for (int k = 0; k < lap_items; k++)
        begin
            row        = '0;
            row.kind   = KIND_RESERVE;
            row.slot   = IDX_W'($urandom);
            row.ok     = 1'($urandom);
            row.length = LEN_W'($urandom);
            inflight_slots.push_back(push_ptr);
            if (inflight_slots.size() > 3)
            begin
                void'(inflight_slots.pop_front());
            end
            send_item(row);
        end

        run_traffic(TRAFFIC_ITEMS, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input transfers and checked %0d results; %0d mismatches.",
                 items_sent, results_checked, fail_count);
        $display("Reads returning data: %0d, largest byte count %0d, ring overruns: %0d.",
                 reads_with_data, largest_count, overrun_passes);
        if (fail_count == 0)
        begin
            $display("tb_transfer_slot_ring_tracker_unit: PASS");
        end
        else
        begin
            $display("tb_transfer_slot_ring_tracker_unit: FAIL");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still awaited.", awaited_results.size());
        $display("tb_transfer_slot_ring_tracker_unit: FAIL");
        $finish;
    end

endmodule

// ===== transfer_slot_ring_tracker_unit.f =====
rtl/tsrt_pkg.sv
rtl/tsrt_slot_ram.sv
rtl/tsrt_walk_seq.sv
rtl/transfer_slot_ring_tracker_unit.sv
tb/sv/tb_transfer_slot_ring_tracker_unit.sv
